### src/range_reply_frame_parser_assert.svh
// Assertion macros used by the range reply frame parser.
`ifndef RANGE_REPLY_FRAME_PARSER_ASSERT_SVH
`define RANGE_REPLY_FRAME_PARSER_ASSERT_SVH

// Same-cycle implication, checked on the rising edge of clk outside reset.
`define RRFP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on the rising edge of clk outside reset.
`define RRFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/rrfp_pkg.sv
// Types and constants of the range reply frame parser.
package rrfp_pkg;

  // Field and state widths.
  localparam int BYTE_W = 8;
  localparam int ACC_W  = 27;
  localparam int CNT_W  = 4;
  localparam int POS_W  = 5;
  localparam int PROD_W = ACC_W + 4;

  // Maximum number of leading digits taken from the value field.
  localparam logic [POS_W-1:0] NUMBER_DIGITS = 5'd8;

  // Frame bytes.
  localparam logic [BYTE_W-1:0] START_BYTE = 8'h25;  // '%'
  localparam logic [BYTE_W-1:0] STAR_BYTE  = 8'h2A;  // '*'
  localparam logic [BYTE_W-1:0] CR_BYTE    = 8'h0D;  // carriage return
  localparam logic [BYTE_W-1:0] TAG_BYTE0  = 8'h52;  // 'R'
  localparam logic [BYTE_W-1:0] TAG_BYTE1  = 8'h4D;  // 'M'
  localparam logic [BYTE_W-1:0] TAG_BYTE2  = 8'h44;  // 'D'
  localparam logic [BYTE_W-1:0] DIGIT_ZERO = 8'h30;  // '0'
  localparam logic [BYTE_W-1:0] DIGIT_NINE = 8'h39;  // '9'

  // Frame offsets.
  localparam logic [POS_W-1:0] TAG_OFFSET   = 5'd4;
  localparam logic [POS_W-1:0] VALUE_OFFSET = 5'd7;
  localparam logic [POS_W-1:0] POS_MAX      = 5'd31;

  // Saturation limits.
  localparam logic [ACC_W-1:0] ACC_MAX    = {ACC_W{1'b1}};
  localparam logic [CNT_W-1:0] DIGITS_MAX = {CNT_W{1'b1}};

  // Digit accumulator state passed between the top level and the digit unit.
  typedef struct packed {
    logic [ACC_W-1:0] value;
    logic [CNT_W-1:0] count;
    logic             stopped;
  } rrfp_digit_t;

endpackage

### src/rrfp_digit_acc.sv
// Decimal digit accumulator: one multiply-by-ten step with saturation.
module rrfp_digit_acc
  import rrfp_pkg::*;
(
  input  logic              enable,
  input  logic [BYTE_W-1:0] rx_byte,
  input  rrfp_digit_t       cur,
  output rrfp_digit_t       nxt
);

  logic              is_digit;
  logic [BYTE_W-1:0] digit_value;
  logic [PROD_W-1:0] product;

  // Classify the byte and form value * 10 + digit.
  assign is_digit    = (rx_byte >= DIGIT_ZERO) && (rx_byte <= DIGIT_NINE);
  assign digit_value = rx_byte - DIGIT_ZERO;
  assign product     = ({4'd0, cur.value} << 3) + ({4'd0, cur.value} << 1)
                     + {{(PROD_W-BYTE_W){1'b0}}, digit_value};

  // Take the digit, or stop at the first non-digit.
  always_comb begin
    nxt = cur;
    if (enable && !cur.stopped) begin
      if (is_digit) begin
        if (product[PROD_W-1:ACC_W] != '0) begin
          nxt.value = ACC_MAX;
        end else begin
          nxt.value = product[ACC_W-1:0];
        end
        if (cur.count != DIGITS_MAX) begin
          nxt.count = cur.count + 1'b1;
        end
      end else begin
        nxt.stopped = 1'b1;
      end
    end
  end

endmodule

### src/range_reply_frame_parser.sv
// Range reply frame parser: one reply byte per transaction in, one distance out
// per closed RMD frame. Each byte is registered at the input and then handled
// by the frame tracker and a multiply-by-ten accumulator, so the block takes
// one byte every clock cycle while the output is not stalled, and a frame's
// result is registered once its closing carriage return leaves the input
// register. A frame opens on '%', must carry "RMD" at offsets 4 to 6, takes
// up to eight leading decimal digits from offset 7 on and closes on "**"
// plus carriage return. The distance is reported as an integer count of
// ten-thousandths. When the output register is held by a stalled sink, one
// more byte is still taken into the input register before the input stalls.
module range_reply_frame_parser
  import rrfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // [26:0] distance_ticks, [30:27] digit_count, [31] zero
);

  `include "range_reply_frame_parser_assert.svh"

  // Input register.
  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;

  // Frame state.
  logic              in_frame;
  logic [POS_W-1:0]  frame_position;
  logic              tag_matched;
  rrfp_digit_t       digits;
  logic [15:0]       last_two_bytes;

  // Next values.
  logic              in_frame_next;
  logic [POS_W-1:0]  frame_position_next;
  logic              tag_matched_next;
  rrfp_digit_t       digits_next;
  rrfp_digit_t       digits_step;
  logic [15:0]       last_two_bytes_next;

  // Output register.
  logic              out_valid;
  logic [ACC_W-1:0]  distance_ticks;
  logic [CNT_W-1:0]  digit_count;

  logic              advance;
  logic              process;
  logic              in_window;
  logic              closing;
  logic              emit;

  // Handshake: the input register moves on when the output register is free.
  assign advance  = !out_valid || m_tready;
  assign s_tready = !in_valid || advance;
  assign process  = in_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  // Value field window and digit accumulation.
  assign in_window = (frame_position >= VALUE_OFFSET)
                  && (frame_position < VALUE_OFFSET + NUMBER_DIGITS);

  rrfp_digit_acc u_digit_acc (
    .enable  (in_window),
    .rx_byte (in_byte),
    .cur     (digits),
    .nxt     (digits_step)
  );

  assign closing = (in_byte == CR_BYTE) && (last_two_bytes == {STAR_BYTE, STAR_BYTE});

  // Frame tracking: start, tag check, terminator and position count.
  always_comb begin
    in_frame_next       = in_frame;
    frame_position_next = frame_position;
    tag_matched_next    = tag_matched;
    digits_next         = digits;
    last_two_bytes_next = last_two_bytes;
    emit                = 1'b0;
    if (!in_frame) begin
      if (in_byte == START_BYTE) begin
        in_frame_next       = 1'b1;
        frame_position_next = 5'd1;
        tag_matched_next    = 1'b0;
        digits_next         = '0;
        last_two_bytes_next = '0;
      end
    end else begin
      if (frame_position == TAG_OFFSET) begin
        tag_matched_next = (in_byte == TAG_BYTE0);
      end else if (frame_position == TAG_OFFSET + 5'd1) begin
        tag_matched_next = tag_matched && (in_byte == TAG_BYTE1);
      end else if (frame_position == TAG_OFFSET + 5'd2) begin
        tag_matched_next = tag_matched && (in_byte == TAG_BYTE2);
      end
      digits_next         = digits_step;
      last_two_bytes_next = {last_two_bytes[7:0], in_byte};
      if (frame_position != POS_MAX) begin
        frame_position_next = frame_position + 1'b1;
      end
      if (closing) begin
        in_frame_next       = 1'b0;
        frame_position_next = '0;
        emit                = tag_matched_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame       <= 1'b0;
      frame_position <= '0;
      tag_matched    <= 1'b0;
      digits         <= '0;
      last_two_bytes <= '0;
    end else if (process) begin
      in_frame       <= in_frame_next;
      frame_position <= frame_position_next;
      tag_matched    <= tag_matched_next;
      digits         <= digits_next;
      last_two_bytes <= last_two_bytes_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= process && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (process && emit) begin
      distance_ticks <= digits_next.value;
      digit_count    <= digits_next.count;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, digit_count, distance_ticks};

  // Checks on the frame tracker and the input register.
  `RRFP_ASSERT_NEXT(a_result_closes_frame, process && emit, !in_frame,
    "frame still open after a result was produced")
  `RRFP_ASSERT_NOW(a_idle_position_zero, !in_frame, frame_position == '0,
    "frame position not zero while idle")
  `RRFP_ASSERT_NOW(a_digit_limit, 1'b1, {1'b0, digits.count} <= NUMBER_DIGITS,
    "more digits taken than the value field allows")
  `RRFP_ASSERT_NOW(a_no_digits_no_value, digits.count == '0, digits.value == '0,
    "value accumulated without any digit")
  `RRFP_ASSERT_NEXT(a_input_holds, in_valid && !advance, in_valid && $stable(in_byte),
    "input register changed while stalled")

endmodule

### bench/range_reply_frame_parser_checker.sv
// Checker that predicts the parsed distances from the byte stream and compares the results.
`timescale 1ns / 1ps
module range_reply_frame_parser_checker
  import rrfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,   // [26:0] distance_ticks, [30:27] digit_count, [31] zero
  output int          fail_count,
  output int          pending_count
);

  typedef struct packed {
    logic [CNT_W-1:0] digits;
    logic [ACC_W-1:0] ticks;
  } distance_t;

  // Shadow copy of the frame tracker.
  logic             in_frame;
  logic [POS_W-1:0] frame_pos;
  logic             tag_ok;
  logic [ACC_W-1:0] accum;
  logic [CNT_W-1:0] digits;
  logic             stopped;
  logic [15:0]      tail;

  // Distances that closed RMD frames have produced but the sink has not taken yet.
  distance_t distance_queue[$];

  // Advance the shadow tracker by one accepted byte and queue a distance on close.
  task automatic parse_reply_byte(input logic [BYTE_W-1:0] b);
    logic      closing;
    longint    grown;
    distance_t entry;
    if (!in_frame) begin
      // Only a start byte matters while idle; it resets the whole frame context.
      if (b == START_BYTE) begin
        in_frame  = 1'b1;
        frame_pos = 5'd1;
        tag_ok    = 1'b0;
        accum     = '0;
        digits    = '0;
        stopped   = 1'b0;
        tail      = '0;
      end
      return;
    end

    // Tag check over offsets 4 to 6.
    if (frame_pos == TAG_OFFSET)
      tag_ok = (b == TAG_BYTE0);
    else if (frame_pos == TAG_OFFSET + 5'd1)
      tag_ok = tag_ok && (b == TAG_BYTE1);
    else if (frame_pos == TAG_OFFSET + 5'd2)
      tag_ok = tag_ok && (b == TAG_BYTE2);

    // Leading digits inside the value window; the first non-digit ends the number.
    if (int'(frame_pos) >= int'(VALUE_OFFSET) &&
        int'(frame_pos) < int'(VALUE_OFFSET) + int'(NUMBER_DIGITS) && !stopped) begin
      if (b >= DIGIT_ZERO && b <= DIGIT_NINE) begin
        grown = longint'(accum) * 10 + longint'(b - DIGIT_ZERO);
        accum = (grown > longint'(ACC_MAX)) ? ACC_MAX : ACC_W'(grown);
        if (digits != DIGITS_MAX)
          digits = digits + 1'b1;
      end else begin
        stopped = 1'b1;
      end
    end

    // A carriage return right after two stars closes the frame.
    closing = (b == CR_BYTE) && (tail == {STAR_BYTE, STAR_BYTE});
    tail = {tail[7:0], b};
    if (frame_pos != POS_MAX)
      frame_pos = frame_pos + 1'b1;

    if (closing) begin
      in_frame  = 1'b0;
      frame_pos = '0;
      if (tag_ok) begin
        entry.digits = digits;
        entry.ticks  = accum;
        distance_queue.push_back(entry);
      end
    end
  endtask

  // Watch both channels at every rising edge.
  always @(posedge clk) begin
    distance_t want;
    if (rst) begin
      in_frame  = 1'b0;
      frame_pos = '0;
      tag_ok    = 1'b0;
      accum     = '0;
      digits    = '0;
      stopped   = 1'b0;
      tail      = '0;
      distance_queue.delete();
    end else begin
      if (s_tvalid && s_tready)
        parse_reply_byte(s_tdata);

      if (m_tvalid && m_tready) begin
        if (distance_queue.size() == 0) begin
          $display("%0t: unexpected transaction, expected none, got %h", $time, m_tdata);
          fail_count++;
        end else begin
          want = distance_queue.pop_front();
          if (m_tdata[26:0] !== want.ticks) begin
            $display("%0t: distance_ticks expected %0d, got %0d",
                     $time, want.ticks, m_tdata[26:0]);
            fail_count++;
          end
          if (m_tdata[30:27] !== want.digits) begin
            $display("%0t: digit_count expected %0d, got %0d",
                     $time, want.digits, m_tdata[30:27]);
            fail_count++;
          end
          if (m_tdata[31] !== 1'b0) begin
            $display("%0t: padding bit expected 0, got %b", $time, m_tdata[31]);
            fail_count++;
          end
        end
      end
    end
    pending_count <= distance_queue.size();
  end

endmodule

### bench/range_reply_frame_parser_tb.sv
// Testbench top for the range reply frame parser: clock, reset, byte stimulus and verdict.
`timescale 1ns / 1ps
module range_reply_frame_parser_tb;
  import rrfp_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_BYTES = 850;
  localparam int DRAIN_CYCLES = 16;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = '0;   // [7:0] rx_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;         // [26:0] distance_ticks, [30:27] digit_count, [31] zero

  int fail_count;
  int pending_count;
  int idle_pct         = 0;
  int stall_pct        = 0;
  int cycle_count      = 0;
  int frame_bytes_sent = 0;

  // Bytes of the reply being assembled.
  logic [7:0] reply[$];

  always #4 clk = ~clk;

  range_reply_frame_parser DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  range_reply_frame_parser_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // Sink backpressure follows the stall rate of the current phase.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("range_reply_frame_parser regression: fail");
      $finish;
    end
  end

  // Offer one byte, with random idle cycles ahead of it, and wait for its transaction.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic push_text(input string text);
    for (int i = 0; i < text.len(); i++)
      reply.push_back(text[i]);
  endtask

  task automatic push_close();
    push_text("**");
    reply.push_back(CR_BYTE);
  endtask

  task automatic send_reply();
    foreach (reply[i])
      send_byte(reply[i]);
    frame_bytes_sent += reply.size();
    reply.delete();
  endtask

  // Bytes between frames: never a start byte, sometimes a stray terminator.
  task automatic send_idle_noise();
    logic [7:0] b;
    repeat ($urandom_range(1, 4)) begin
      b = 8'($urandom_range(255));
      if (b == START_BYTE)
        b = STAR_BYTE;
      send_byte(b);
    end
    if ($urandom_range(3) == 0) begin
      send_byte(STAR_BYTE);
      send_byte(STAR_BYTE);
      send_byte(CR_BYTE);
    end
  endtask

  // Mostly well-formed RMD replies with random content, some with a bad tag,
  // overlong numbers, long padding or a broken star pair before the real end.
  task automatic build_random_reply();
    int shape;
    int n_digits;
    int n_pad;
    shape = $urandom_range(99);
    reply.push_back(START_BYTE);
    repeat (3) reply.push_back(8'($urandom_range(255)));
    push_text("RMD");
    if (shape >= 80)
      reply[4 + $urandom_range(2)] = 8'($urandom_range(255));
    n_digits = ($urandom_range(9) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 8);
    repeat (n_digits) reply.push_back(DIGIT_ZERO + 8'($urandom_range(9)));
    if ($urandom_range(1) == 1) begin
      n_pad = ($urandom_range(11) == 0) ? $urandom_range(18, 28) : $urandom_range(1, 5);
      repeat (n_pad) reply.push_back(8'($urandom_range(255)));
    end
    if (shape >= 92) begin
      push_text("**");
      reply.push_back(8'($urandom_range(255)));
    end
    push_close();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: ignored bytes and a stray terminator while idle.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(STAR_BYTE);
    send_byte(STAR_BYTE);
    send_byte(CR_BYTE);

    // Largest value, with extreme bytes and a percent sign in the unchecked offsets.
    reply.push_back(START_BYTE);
    reply.push_back(8'h00);
    reply.push_back(8'hFF);
    reply.push_back(START_BYTE);
    push_text("RMD99999999");
    push_close();
    send_reply();

    // A single zero digit.
    push_text("%XYZRMD0");
    push_close();
    send_reply();

    // Digits beyond the window are ignored.
    push_text("%000RMD123456789012");
    push_close();
    send_reply();

    // Sign, point and exponent stop the number at once.
    push_text("%000RMD-12.5e3");
    push_close();
    send_reply();

    // A point after two digits.
    push_text("%000RMD31.5");
    push_close();
    send_reply();

    // Terminator inside the digit window.
    push_text("%000RMD12");
    push_close();
    send_reply();

    // Terminator before the tag, then a wrong tag: both close without a result.
    push_text("%00");
    push_close();
    push_text("%000RME55");
    push_close();
    send_reply();

    // Leading zeros.
    push_text("%000RMD00000001");
    push_close();
    send_reply();

    // Long frame that drives the position counter into saturation.
    push_text("%000RMD7");
    repeat (30) push_text("x");
    push_close();
    send_reply();

    // Random part in four pressure phases.
    frame_bytes_sent = 0;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 60;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 60;
        end
        default: begin
          idle_pct  = 29;
          stall_pct = 29;
        end
      endcase
      while (frame_bytes_sent < (phase + 1) * RANDOM_BYTES / 4) begin
        if ($urandom_range(3) == 0)
          send_idle_noise();
        build_random_reply();
        send_reply();
      end
    end
    s_tvalid <= 1'b0;
    @(posedge clk);

    // Drain the outstanding distances, then give the pipeline time to settle.
    while (pending_count != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending_count == 0) begin
      $display("range_reply_frame_parser regression: pass");
    end else begin
      $display("range_reply_frame_parser regression: fail");
    end
    $finish;
  end

endmodule

### range_reply_frame_parser.f
+incdir+src
src/rrfp_pkg.sv
src/rrfp_digit_acc.sv
src/range_reply_frame_parser.sv
bench/range_reply_frame_parser_checker.sv
bench/range_reply_frame_parser_tb.sv
